/* rtl/dtfp_pkg.sv */
// Shared types, constants and a digit test for the date-time field parser.
package dtfp_pkg;

  localparam int unsigned NUM_STORED = 5;
  localparam int unsigned NUM_FIELDS = 6;
  localparam int unsigned IDX_W      = 3;

  localparam logic [IDX_W-1:0] IDX_LAST     = 3'd5;
  localparam logic [IDX_W-1:0] IDX_OVERFLOW = 3'd6;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // result handoff from the parse core to the output stage
  typedef struct packed {
    logic emit;
    logic ok;
  } dtfp_ctl_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c inside {[CHAR_ZERO:CHAR_NINE]};
  endfunction

endpackage

/* rtl/dtfp_in_stage.sv */
// Input register stage: holds one byte beat until the parse core takes it.
module dtfp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       move_i,
  output logic       vld_o,
  output logic [7:0] byte_o
);

  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;

  assign in_ready = !vld_r || move_i;
  assign vld_nxt  = in_ready ? in_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_char_byte;
    end
  end

  assign vld_o  = vld_r;
  assign byte_o = byte_r;

endmodule

/* rtl/dtfp_parse_core.sv */
// Parse state and per-byte update: digit accumulate, separator runs, error tracking.
module dtfp_parse_core #(
  parameter int unsigned FIELD_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire_i,
  input  logic [7:0]            byte_i,
  output dtfp_pkg::dtfp_ctl_t   ctl_o,
  output logic [FIELD_WIDTH-1:0] fields_o [dtfp_pkg::NUM_FIELDS]
);

  localparam int unsigned PW = FIELD_WIDTH + 4;

  logic [dtfp_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [FIELD_WIDTH-1:0]     acc_r, acc_nxt;
  logic                       first_r, first_nxt;
  logic                       skip_r, skip_nxt;
  logic                       err_r, err_nxt;
  logic [FIELD_WIDTH-1:0]     stored_r [dtfp_pkg::NUM_STORED];
  logic                       store_en;

  logic                       term, digit, ok;
  logic [PW-1:0]              prod, acc_ext, sat_max;

  assign term  = (byte_i == dtfp_pkg::CHAR_NUL);
  assign digit = dtfp_pkg::is_digit(byte_i);
  assign ok    = !err_r && !first_r && (idx_r == dtfp_pkg::IDX_LAST);

  // acc*10 + digit, four bits wider than the field so saturation can be seen
  assign acc_ext = {4'b0, acc_r};
  assign prod    = (acc_ext << 3) + (acc_ext << 1) + {{FIELD_WIDTH{1'b0}}, byte_i[3:0]};
  assign sat_max = {4'b0, {FIELD_WIDTH{1'b1}}};

  always_comb begin
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    first_nxt = first_r;
    skip_nxt  = skip_r;
    err_nxt   = err_r;
    store_en  = 1'b0;
    if (fire_i) begin
      if (term) begin
        // clear for the next string
        idx_nxt   = '0;
        acc_nxt   = '0;
        first_nxt = 1'b1;
        skip_nxt  = 1'b0;
        err_nxt   = 1'b0;
      end else begin
        first_nxt = 1'b0;
        if (first_r && !digit) begin
          err_nxt = 1'b1;
        end else if (!err_r) begin
          if (digit) begin
            acc_nxt  = (prod > sat_max) ? {FIELD_WIDTH{1'b1}} : prod[FIELD_WIDTH-1:0];
            skip_nxt = 1'b0;
          end else if (!skip_r) begin
            if (idx_r < dtfp_pkg::IDX_LAST) begin
              store_en = 1'b1;
              idx_nxt  = idx_r + 3'd1;
            end else begin
              idx_nxt = dtfp_pkg::IDX_OVERFLOW;
              err_nxt = 1'b1;
            end
            acc_nxt  = '0;
            skip_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      acc_r   <= '0;
      first_r <= 1'b1;
      skip_r  <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      first_r <= first_nxt;
      skip_r  <= skip_nxt;
      err_r   <= err_nxt;
    end
  end

  // stored fields are only read once all five have been written this string
  always_ff @(posedge clk) begin
    for (int k = 0; k < dtfp_pkg::NUM_STORED; k++) begin
      if (store_en && (idx_r == k[dtfp_pkg::IDX_W-1:0])) begin
        stored_r[k] <= acc_r;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < dtfp_pkg::NUM_STORED; k++) begin
      fields_o[k] = ok ? stored_r[k] : '0;
    end
    fields_o[dtfp_pkg::NUM_FIELDS-1] = ok ? acc_r : '0;
  end

  assign ctl_o.emit = fire_i && term;
  assign ctl_o.ok   = ok;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= dtfp_pkg::IDX_OVERFLOW)
    else $error("field index out of range");

  a_overflow_err: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r == dtfp_pkg::IDX_OVERFLOW) |-> err_r)
    else $error("too many fields without error flag");

  a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_i && !term) |=> !first_r)
    else $error("first-byte flag not cleared");

  a_term_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_i && term) |=> (first_r && !err_r && idx_r == '0 && acc_r == '0))
    else $error("state not cleared after terminator");

endmodule

/* rtl/dtfp_out_stage.sv */
// Result register: holds one result beat until the consumer takes it.
module dtfp_out_stage #(
  parameter int unsigned FIELD_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dtfp_pkg::dtfp_ctl_t    ctl_i,
  input  logic [FIELD_WIDTH-1:0] fields_i [dtfp_pkg::NUM_FIELDS],
  output logic                   free_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FIELD_WIDTH-1:0] fields_o [dtfp_pkg::NUM_FIELDS],
  output logic                   ok_o
);

  logic                   vld_r, vld_nxt;
  logic [FIELD_WIDTH-1:0] fields_r [dtfp_pkg::NUM_FIELDS];
  logic                   ok_r;

  assign free_o  = !vld_r || out_ready;
  assign vld_nxt = ctl_i.emit ? 1'b1 : (out_ready ? 1'b0 : vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.emit) begin
      fields_r <= fields_i;
      ok_r     <= ctl_i.ok;
    end
  end

  assign out_valid = vld_r;
  assign fields_o  = fields_r;
  assign ok_o      = ok_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.emit |-> free_o)
    else $error("result loaded while previous one still waits");

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r) |-> $past(ctl_i.emit))
    else $error("result valid without a terminator");

endmodule

/* rtl/datetime_field_parser.sv */
// Top level of the date-time field parser: input stage, parse core, result register.
//
// Feed a date-time text one byte per beat on in_char_byte; a zero byte ends the
// string. Runs of decimal digits become the six fields year, month, day, hour,
// minute and second in that order, and any run of non-digit bytes separates
// them. On the terminating byte one result beat comes out with the six values
// and parse_ok; parse_ok is 1 only when the string starts with a digit and
// holds exactly six fields (a separator right before the terminator after the
// fifth field is accepted and gives second = 0). All values are 0 when
// parse_ok is 0, and a field larger than 2^FIELD_WIDTH-1 saturates there.
// Other bytes produce no result. The block takes one byte every cycle unless a
// terminator is waiting: each byte needs only one multiply-by-ten add and compare
// in the parse core. A terminating byte passes from the input register through
// the combinational result path of the parse core into the result register; it
// waits in the input register only while the result register still holds an
// untaken result, and non-terminating bytes keep flowing past a waiting result.
// No clearing pass is needed after reset.
module datetime_field_parser #(
  parameter int unsigned FIELD_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_char_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [FIELD_WIDTH-1:0] out_year,
  output logic [FIELD_WIDTH-1:0] out_month,
  output logic [FIELD_WIDTH-1:0] out_day,
  output logic [FIELD_WIDTH-1:0] out_hour,
  output logic [FIELD_WIDTH-1:0] out_minute,
  output logic [FIELD_WIDTH-1:0] out_second,
  output logic                   out_parse_ok
);

  logic                   s1_vld, s1_move, out_free;
  logic [7:0]             s1_byte;
  dtfp_pkg::dtfp_ctl_t    ctl;
  logic [FIELD_WIDTH-1:0] core_fields [dtfp_pkg::NUM_FIELDS];
  logic [FIELD_WIDTH-1:0] res_fields  [dtfp_pkg::NUM_FIELDS];

  // advance a byte unless it is a terminator and the result register is busy
  assign s1_move = s1_vld && ((s1_byte != dtfp_pkg::CHAR_NUL) || out_free);

  dtfp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .move_i       (s1_move),
    .vld_o        (s1_vld),
    .byte_o       (s1_byte)
  );

  dtfp_parse_core #(.FIELD_WIDTH(FIELD_WIDTH)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (s1_move),
    .byte_i   (s1_byte),
    .ctl_o    (ctl),
    .fields_o (core_fields)
  );

  dtfp_out_stage #(.FIELD_WIDTH(FIELD_WIDTH)) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (ctl),
    .fields_i  (core_fields),
    .free_o    (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .fields_o  (res_fields),
    .ok_o      (out_parse_ok)
  );

  assign out_year   = res_fields[0];
  assign out_month  = res_fields[1];
  assign out_day    = res_fields[2];
  assign out_hour   = res_fields[3];
  assign out_minute = res_fields[4];
  assign out_second = res_fields[5];

endmodule

/* test/tb_datetime_field_parser.sv */
// Testbench for the date-time field parser: byte-stream stimulus, scoreboard and result checks.
`timescale 1ns / 100ps

module tb_datetime_field_parser;

  localparam int unsigned FW = 16;
  localparam longint unsigned FIELD_MAX = (64'd1 << FW) - 1;
  // Stop offering new strings once this many bytes have gone in.
  localparam int unsigned BYTE_BUDGET = 1700;
  // Cycles without any beat on either side before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold after the 8th or 45th result plus a sender gap.
  localparam int unsigned STALL_LIMIT = 2000;

  // One parsed date-time result as it leaves the block.
  typedef struct packed {
    logic [FW-1:0] year;
    logic [FW-1:0] month;
    logic [FW-1:0] day;
    logic [FW-1:0] hour;
    logic [FW-1:0] minute;
    logic [FW-1:0] second;
    logic          ok;
  } dt_result_t;

  // Track the parse state of the current string and queue the parsed
  // fields that each terminating byte should produce.
  class dt_scoreboard;
    logic [dtfp_pkg::IDX_W-1:0] sep_runs;
    logic [FW-1:0]              acc;
    logic [FW-1:0]              done_fields [dtfp_pkg::NUM_STORED];
    bit                         fresh;
    bit                         in_sep;
    bit                         bad;
    dt_result_t                 want_q [$];
    int unsigned                errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      sep_runs = '0;
      acc      = '0;
      foreach (done_fields[i]) done_fields[i] = '0;
      fresh    = 1'b1;
      in_sep   = 1'b0;
      bad      = 1'b0;
    endfunction

    // Advance the parse state by one accepted byte.
    function void note_byte(logic [7:0] c);
      dt_result_t       r;
      longint unsigned  v;
      bit               dig;
      dig = (c >= dtfp_pkg::CHAR_ZERO) && (c <= dtfp_pkg::CHAR_NINE);
      if (c == dtfp_pkg::CHAR_NUL) begin
        r = '0;
        if (!bad && !fresh && sep_runs == dtfp_pkg::IDX_LAST) begin
          r.year   = done_fields[0];
          r.month  = done_fields[1];
          r.day    = done_fields[2];
          r.hour   = done_fields[3];
          r.minute = done_fields[4];
          r.second = acc;
          r.ok     = 1'b1;
        end
        want_q.push_back(r);
        clear();
        return;
      end
      // The string must open with a digit.
      if (fresh) begin
        fresh = 1'b0;
        if (!dig) bad = 1'b1;
      end
      if (bad) return;
      if (dig) begin
        v      = 64'(acc) * 10 + 64'(c - dtfp_pkg::CHAR_ZERO);
        acc    = (v > FIELD_MAX) ? FW'(FIELD_MAX) : FW'(v);
        in_sep = 1'b0;
      end else if (!in_sep) begin
        // First byte of a separator run closes the field being built.
        if (sep_runs < dtfp_pkg::IDX_LAST) begin
          done_fields[sep_runs] = acc;
          sep_runs++;
        end else begin
          sep_runs = dtfp_pkg::IDX_OVERFLOW;
          bad      = 1'b1;
        end
        acc    = '0;
        in_sep = 1'b1;
      end
    endfunction

    function void cmp(string name, logic [FW-1:0] want, logic [FW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat against the oldest expectation.
    function void check_result(dt_result_t got);
      dt_result_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got year %0d ok %0b",
                 $time, got.year, got.ok);
        errors++;
        return;
      end
      w = want_q.pop_front();
      cmp("year",     w.year,   got.year);
      cmp("month",    w.month,  got.month);
      cmp("day",      w.day,    got.day);
      cmp("hour",     w.hour,   got.hour);
      cmp("minute",   w.minute, got.minute);
      cmp("second",   w.second, got.second);
      cmp("parse_ok", FW'(w.ok), FW'(got.ok));
    endfunction

    function int unsigned pending();
      return want_q.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [7:0]    in_char_byte = 8'h00;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [FW-1:0] out_year;
  logic [FW-1:0] out_month;
  logic [FW-1:0] out_day;
  logic [FW-1:0] out_hour;
  logic [FW-1:0] out_minute;
  logic [FW-1:0] out_second;
  logic          out_parse_ok;

  dt_scoreboard  sb = new();
  logic [7:0]    text_q [$];
  int unsigned   bytes_sent = 0;
  bit            in_calm = 1'b0;

  datetime_field_parser #(.FIELD_WIDTH(FW)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .out_hour     (out_hour),
    .out_minute   (out_minute),
    .out_second   (out_second),
    .out_parse_ok (out_parse_ok)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte, hold it until the beat is taken, then log it.
  task automatic send_byte(input logic [7:0] c);
    int unsigned gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(c);
    bytes_sent++;
  endtask

  // Send the queued text followed by its terminator, then drop the queue.
  task automatic send_string();
    foreach (text_q[i]) send_byte(text_q[i]);
    send_byte(dtfp_pkg::CHAR_NUL);
    text_q.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_string();
  endtask

  // Mostly short numbers; a few long enough to saturate the field.
  function automatic void add_number();
    int unsigned n;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 7);
    repeat (n) text_q.push_back(dtfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // A separator run of one to three non-digit, non-zero bytes.
  function automatic void add_separator();
    int unsigned n;
    logic [7:0]  c;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0:       c = "-";
        1:       c = ":";
        2:       c = " ";
        3:       c = "T";
        4:       c = "/";
        default: begin
          do c = 8'($urandom_range(1, 255));
          while (c >= dtfp_pkg::CHAR_ZERO && c <= dtfp_pkg::CHAR_NINE);
        end
      endcase
      text_q.push_back(c);
    end
  endfunction

  // Number, then seps separator runs each followed by a number; drop the
  // number after the last run unless tail is set.
  function automatic void add_fields(int unsigned seps, bit tail);
    add_number();
    for (int unsigned i = 0; i < seps; i++) begin
      add_separator();
      if (i + 1 < seps || tail) add_number();
    end
  endfunction

  // Sender: reset, directed corner strings, then random strings.
  initial begin : stimulus
    int unsigned r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty string.
    send_text("");
    // Leading non-digit, using the top byte value.
    text_q.push_back(8'hFF);
    send_string();
    // Too few fields, with the lowest non-terminating byte as separator.
    text_q.push_back("1");
    text_q.push_back(8'h01);
    text_q.push_back("2");
    send_string();
    // Saturating year and an empty last field after the fifth separator run.
    send_text("99999-0-0 0:0:");
    // A sixth separator run makes the string bad.
    send_text("0/0/0/0/0/0/");

    while (bytes_sent < BYTE_BUDGET) begin
      in_calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        // Well-formed: six fields, sometimes with the last one empty.
        add_fields(5, $urandom_range(0, 9) != 0);
      end else if (r < 78) begin
        add_fields($urandom_range(0, 4), 1'b1);
      end else if (r < 86) begin
        add_fields(6, $urandom_range(0, 1) != 0);
      end else if (r < 91) begin
        add_separator();
        add_fields(5, 1'b1);
      end else if (r < 95) begin
        // Empty string: terminator only.
      end else begin
        repeat ($urandom_range(1, 30)) text_q.push_back(8'($urandom_range(1, 255)));
      end
      send_string();
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected result, then keep watching for strays.
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Receiver: check each result beat and drive out_ready. Toggle between
  // calm stretches (always ready) and random stalls; after the 8th and 45th
  // results hold off so the block backs up into its input.
  initial begin : receiver
    int unsigned hold;
    int unsigned taken;
    bit          calm;
    dt_result_t  got;
    hold  = 0;
    taken = 0;
    calm  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.year   = out_year;
        got.month  = out_month;
        got.day    = out_day;
        got.hour   = out_hour;
        got.minute = out_minute;
        got.second = out_second;
        got.ok     = out_parse_ok;
        sb.check_result(got);
        taken++;
        if (taken == 8 || taken == 45) hold = 400;
      end
      if ($urandom_range(0, 99) == 0) calm = !calm;
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet, sb.pending());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule

/* filelist.f */
rtl/dtfp_pkg.sv
rtl/dtfp_in_stage.sv
rtl/dtfp_parse_core.sv
rtl/dtfp_out_stage.sv
rtl/datetime_field_parser.sv
test/tb_datetime_field_parser.sv
